/* hdl/sha1_pkg.sv */
`default_nettype none
package sha1_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned HashWords = 5;
  localparam int unsigned BlkBits  = 512;
  localparam int unsigned Rounds   = 80;
  localparam int unsigned SchedWin = 16;
  localparam int unsigned LenBytes = 8;
  localparam int unsigned CntW     = 61;  // byte count; bit count is this with 3 zero bits

  typedef logic [WordW-1:0] word_t;
  typedef word_t [HashWords-1:0] vars_t;

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam vars_t Iv = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                          32'hEFCDAB89, 32'h67452301};

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LastPos = 6'd63;
  localparam logic [5:0] LenPos  = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FIN,
    ST_OUT
  } state_e;

  // schedule line control
  typedef struct packed {
    logic byte_en;   // shift one message byte in
    logic round_en;  // advance one round
    logic expand;    // round 16 and up: produce expanded word
  } sched_ctl_t;

  function automatic word_t rotl(word_t v, int unsigned n);
    return (v << n) | (v >> (WordW - n));
  endfunction

endpackage
`default_nettype wire

/* hdl/sha1_stream_hasher.sv */
`default_nettype none
// SHA-1 over a byte stream. Each input transaction carries one message byte
// (tuser high marks the byte as part of the message) and tlast ends the
// message. The byte that fills a 64-byte block starts the compression,
// 80 rounds at one round per cycle on one shared round unit followed by
// a fold into the chaining words. On tlast the block generates the
// padding and length bytes itself, one per cycle, with one or two
// compressions, then presents the five digest words, index 0 (most
// significant) first, with tlast on the fifth. The input is not ready
// from the end of a message until the last digest word is taken; the
// state then returns to the initial values for the next message.
module sha1_stream_hasher
  import sha1_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // data_byte
  input  wire logic        s_axis_tuser_i,   // byte_valid
  input  wire logic        s_axis_tlast_i,   // msg_end
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // digest_word
  output logic [2:0]       m_axis_tuser_o,   // word_index
  output logic             m_axis_tlast_o    // last_word
);

  state_e          state_q, state_d;
  logic [6:0]      rnd_q;
  logic [CntW-1:0] cnt_q, cnt_inc;
  logic            pad_q, first_q;
  logic [3:0]      lcnt_q;
  logic [63:0]     len_q;
  logic [2:0]      idx_q;
  vars_t           h_q, wk_q, wk_n;

  sched_ctl_t ctl;
  logic [7:0] sbyte;
  logic       in_acc, out_acc, start_pad, clr_first, len_shift, done_out;
  logic [5:0] pos;
  word_t      wr;

  assign pos     = cnt_q[5:0];
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign cnt_inc = cnt_q + CntW'(ctl.byte_en);

  always_comb begin
    state_d   = state_q;
    ctl       = '0;
    sbyte     = s_axis_tdata_i;
    start_pad = 1'b0;
    clr_first = 1'b0;
    len_shift = 1'b0;
    done_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ctl.byte_en = s_axis_tuser_i;
          start_pad   = s_axis_tlast_i;
          if (s_axis_tuser_i && pos == LastPos) begin
            state_d = ST_COMP;
          end else if (s_axis_tlast_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ctl.byte_en = 1'b1;
        if (first_q) begin
          sbyte     = PadMark;
          clr_first = 1'b1;
        end else if (lcnt_q == 4'd0 && pos != LenPos) begin
          sbyte = 8'h00;
        end else begin
          sbyte     = len_q[63:56];
          len_shift = 1'b1;
        end
        if (pos == LastPos) begin
          state_d = ST_COMP;
        end
      end
      ST_COMP: begin
        ctl.round_en = 1'b1;
        ctl.expand   = (rnd_q >= 7'(SchedWin));
        if (rnd_q == 7'(Rounds - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!pad_q) begin
          state_d = ST_IDLE;
        end else if (lcnt_q == 4'(LenBytes)) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_acc && idx_q == 3'(HashWords - 1)) begin
          done_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q   <= '0;
      cnt_q   <= '0;
      pad_q   <= 1'b0;
      first_q <= 1'b0;
      lcnt_q  <= '0;
      idx_q   <= '0;
      h_q     <= Iv;
    end else begin
      rnd_q <= (state_q == ST_COMP) ? rnd_q + 7'd1 : 7'd0;
      cnt_q <= done_out ? '0 : cnt_inc;
      if (start_pad) begin
        pad_q   <= 1'b1;
        first_q <= 1'b1;
        lcnt_q  <= '0;
      end
      if (clr_first) begin
        first_q <= 1'b0;
      end
      if (len_shift) begin
        lcnt_q <= lcnt_q + 4'd1;
      end
      if (state_q == ST_FIN) begin
        for (int i = 0; i < HashWords; i++) begin
          h_q[i] <= h_q[i] + wk_q[i];
        end
      end
      if (done_out) begin
        idx_q <= '0;
      end else if (out_acc) begin
        idx_q <= idx_q + 3'd1;
      end
      if (done_out) begin
        h_q   <= Iv;
        pad_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start_pad) begin
      len_q <= {cnt_inc, 3'b000};
    end else if (len_shift) begin
      len_q <= {len_q[55:0], 8'h00};
    end
    if (state_q != ST_COMP && state_d == ST_COMP) begin
      wk_q <= h_q;
    end else if (state_q == ST_COMP) begin
      wk_q <= wk_n;
    end
  end

  sha1_sched u_sched (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .byte_i (sbyte),
    .w_o    (wr)
  );

  sha1_round u_round (
    .v_i   (wk_q),
    .w_i   (wr),
    .rnd_i (rnd_q),
    .v_o   (wk_n)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tdata_o  = h_q[idx_q];
  assign m_axis_tuser_o  = idx_q;
  assign m_axis_tlast_o  = (idx_q == 3'(HashWords - 1));

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while digest pending");

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COMP |-> rnd_q < 7'(Rounds))
    else $error("round counter out of range");

  a_block_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN |-> cnt_q[5:0] == 6'd0)
    else $error("compression finished off a block boundary");

  a_out_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_FIN))
    else $error("digest shown without a finished compression");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> idx_q < 3'(HashWords))
    else $error("digest word index out of range");
`endif

endmodule
`default_nettype wire

/* hdl/sha1_sched.sv */
`default_nettype none
module sha1_sched
  import sha1_pkg::*;
(
  input  wire logic       clk_i,
  input  wire sched_ctl_t ctl_i,
  input  wire logic [7:0] byte_i,
  output word_t           w_o
);

  // 16-word window, word 0 in the top bits. Bytes shift in at the bottom,
  // so after 64 bytes the first byte sits at the top of word 0.
  logic [BlkBits-1:0] line_q, line_d;
  word_t w0, w2, w8, w13, wnew;

  assign w0  = line_q[BlkBits-1        -: WordW];
  assign w2  = line_q[BlkBits-1-2*WordW  -: WordW];
  assign w8  = line_q[BlkBits-1-8*WordW  -: WordW];
  assign w13 = line_q[BlkBits-1-13*WordW -: WordW];

  always_comb begin
    wnew = ctl_i.expand ? rotl(w13 ^ w8 ^ w2 ^ w0, 1) : w0;
    line_d = line_q;
    if (ctl_i.byte_en) begin
      line_d = {line_q[BlkBits-9:0], byte_i};
    end else if (ctl_i.round_en) begin
      line_d = {line_q[BlkBits-WordW-1:0], wnew};
    end
  end

  always_ff @(posedge clk_i) begin
    line_q <= line_d;
  end

  assign w_o = wnew;

endmodule
`default_nettype wire

/* hdl/sha1_round.sv */
`default_nettype none
module sha1_round
  import sha1_pkg::*;
(
  input  wire vars_t      v_i,
  input  wire word_t      w_i,
  input  wire logic [6:0] rnd_i,
  output vars_t           v_o
);

  word_t f, k, t;

  always_comb begin
    if (rnd_i < 7'd20) begin
      f = v_i[3] ^ (v_i[1] & (v_i[2] ^ v_i[3]));
      k = K0;
    end else if (rnd_i < 7'd40) begin
      f = v_i[1] ^ v_i[2] ^ v_i[3];
      k = K1;
    end else if (rnd_i < 7'd60) begin
      f = (v_i[1] & v_i[2]) | (v_i[1] & v_i[3]) | (v_i[2] & v_i[3]);
      k = K2;
    end else begin
      f = v_i[1] ^ v_i[2] ^ v_i[3];
      k = K3;
    end
    t = rotl(v_i[0], 5) + f + v_i[4] + k + w_i;
    v_o[0] = t;
    v_o[1] = v_i[0];
    v_o[2] = rotl(v_i[1], 30);
    v_o[3] = v_i[2];
    v_o[4] = v_i[3];
  end

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  typedef logic [4:0][31:0] digest_t;  // element 0 is H0, the most significant word

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_byte;
    logic       is_end;
    logic       has_ref;
    digest_t    ref_dg;
  } stim_row_t;

  localparam digest_t IvWords = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                 32'hEFCDAB89, 32'h67452301};
  localparam logic [31:0] KRound0 = 32'h5A827999;
  localparam logic [31:0] KRound1 = 32'h6ED9EBA1;
  localparam logic [31:0] KRound2 = 32'h8F1BBCDC;
  localparam logic [31:0] KRound3 = 32'hCA62C1D6;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [5:0]  LenStart = 6'd56;
  localparam logic [5:0]  BlockEnd = 6'd63;

  // well-known digests
  localparam digest_t EmptyDigest = {32'hAFD80709, 32'h95601890, 32'h3255BFEF,
                                     32'h5E6B4B0D, 32'hDA39A3EE};
  localparam digest_t AbcDigest   = {32'h9CD0D89D, 32'h7850C26C, 32'hBA3E2571,
                                     32'h4706816A, 32'hA9993E36};
  localparam digest_t NoDigest    = '0;

  localparam int NumDirected = 12;
  localparam int RandItems   = 200;
  localparam int DrainCycles = 400;

  logic        clk;
  logic        rst_n;
  logic        s_valid;
  logic        s_ready;
  logic [7:0]  s_data;
  logic        s_user;
  logic        s_last;
  logic        m_valid;
  logic        m_rdy;
  logic [31:0] m_data;
  logic [2:0]  m_user;
  logic        m_last;

  int unsigned idle_pct;
  int unsigned n_err;
  int unsigned n_items;
  int unsigned n_msgs;
  int unsigned n_words;

  digest_beat_t pending_words[$];

  // hash state mirrored by the predictor
  digest_t           chain;
  logic [15:0][31:0] blk;
  logic [63:0]       nbits;

  sha1_stream_hasher u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_rdy),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("sha1_stream_hasher: mismatch");
    $finish;
  end

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
    logic [63:0] two;
    two = {v, v} << n;
    return two[63:32];
  endfunction

  function automatic void sha_compress();
    logic [15:0][31:0] w;
    logic [31:0] a, b, c, d, e, f, k, t;
    w = blk;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16)
        w[r % 16] = rol32(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^
                          w[r % 16], 1);
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = KRound0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = KRound1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = KRound2;
      end else begin
        f = b ^ c ^ d;
        k = KRound3;
      end
      t = rol32(a, 5) + f + e + k + w[r % 16];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
    chain[4] = chain[4] + e;
  endfunction

  function automatic void sha_absorb_byte(input logic [7:0] b);
    logic [5:0] pos;
    pos = nbits[8:3];
    blk[pos[5:2]][8 * (3 - pos[1:0]) +: 8] = b;
    nbits = nbits + 64'd8;
    if (pos == BlockEnd)
      sha_compress();
  endfunction

  // padding and length, then back to the initial values
  function automatic digest_t sha_close_message();
    logic [63:0] len;
    digest_t     dg;
    len = nbits;
    sha_absorb_byte(PadByte);
    while (nbits[8:3] != LenStart)
      sha_absorb_byte(8'h00);
    for (int i = 7; i >= 0; i--)
      sha_absorb_byte(len[8 * i +: 8]);
    dg = chain;
    chain = IvWords;
    nbits = '0;
    return dg;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    n_err++;
    if (n_err <= 40)
      $display("ERROR at %0t: %s got %h want %h", $time, what, got, want);
  endtask

  task automatic put_item(input logic [7:0] b, input logic v, input logic e,
                          input logic has_ref, input digest_t ref_dg);
    digest_t      dg;
    digest_beat_t beat;
    while ($urandom_range(99) < idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_user  <= v;
    s_last  <= e;
    @(posedge clk);
    while (!s_ready)
      @(posedge clk);
    n_items++;
    if (v)
      sha_absorb_byte(b);
    if (e) begin
      dg = sha_close_message();
      if (has_ref)
        dg = ref_dg;
      n_msgs++;
      for (int i = 0; i < 5; i++) begin
        beat.word = dg[i];
        beat.idx  = 3'(i);
        beat.last = (i == 4);
        pending_words.push_back(beat);
      end
    end
  endtask

  // result side: random backpressure, each accepted transaction checked
  initial begin
    digest_beat_t want;
    m_rdy = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && m_valid && m_rdy) begin
        n_words++;
        if (pending_words.size() == 0) begin
          flag_mismatch("unexpected digest word", m_data, 32'h0);
        end else begin
          want = pending_words.pop_front();
          if (m_data !== want.word)
            flag_mismatch("digest_word", m_data, want.word);
          if (m_user !== want.idx)
            flag_mismatch("word_index", 32'(m_user), 32'(want.idx));
          if (m_last !== want.last)
            flag_mismatch("last_word", 32'(m_last), 32'(want.last));
        end
      end
      m_rdy <= ($urandom_range(99) >= idle_pct);
    end
  end

  initial begin
    stim_row_t dir_tab [NumDirected];
    int        len;
    int        n_rand;
    int        boundary_len [4];
    logic      end_on_byte;

    s_valid  = 1'b0;
    s_data   = '0;
    s_user   = 1'b0;
    s_last   = 1'b0;
    rst_n    = 1'b0;
    idle_pct = 24;
    n_err    = 0;
    n_items  = 0;
    n_msgs   = 0;
    n_words  = 0;
    chain    = IvWords;
    blk      = '0;
    nbits    = '0;

    boundary_len = '{55, 56, 63, 64};

    // empty message, "abc", byte extremes, end with and without a byte
    dir_tab = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},
      '{8'hA5, 1'b0, 1'b0, 1'b0, NoDigest},
      '{8'h61, 1'b1, 1'b0, 1'b0, NoDigest},
      '{8'h62, 1'b1, 1'b0, 1'b0, NoDigest},
      '{8'h63, 1'b1, 1'b1, 1'b1, AbcDigest},
      '{8'h00, 1'b1, 1'b0, 1'b0, NoDigest},
      '{8'hFF, 1'b1, 1'b0, 1'b0, NoDigest},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NoDigest},
      '{8'h5A, 1'b0, 1'b1, 1'b0, NoDigest},
      '{8'hFF, 1'b1, 1'b1, 1'b0, NoDigest},
      '{8'hC3, 1'b0, 1'b1, 1'b1, EmptyDigest},
      '{8'h00, 1'b1, 1'b1, 1'b0, NoDigest}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumDirected; i++)
      put_item(dir_tab[i].data, dir_tab[i].is_byte, dir_tab[i].is_end,
               dir_tab[i].has_ref, dir_tab[i].ref_dg);

    // random messages, mostly short, some around the padding boundaries
    n_rand = 0;
    while (n_rand < RandItems) begin
      idle_pct = (n_rand >= 70 && n_rand < 140) ? 0 : 24;
      if ($urandom_range(3) == 0)
        len = boundary_len[$urandom_range(3)];
      else
        len = $urandom_range(12);
      end_on_byte = (len > 0) && ($urandom_range(1) == 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0)
          put_item(8'($urandom), 1'b0, 1'b0, 1'b0, NoDigest);
        put_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1), 1'b0, NoDigest);
      end
      if (!end_on_byte)
        put_item(8'($urandom), 1'b0, 1'b1, 1'b0, NoDigest);
      n_rand += len + (end_on_byte ? 0 : 1);
    end
    s_valid <= 1'b0;

    while (pending_words.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d input transactions in %0d messages, %0d digest words seen",
             n_items, n_msgs, n_words);
    $display("random part: %0d message items, boundary lengths 55/56/63/64 mixed in",
             n_rand);
    if (n_err == 0) begin
      $display("sha1_stream_hasher: match");
    end else begin
      $display("%0d field errors", n_err);
      $display("sha1_stream_hasher: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/sha1_pkg.sv
hdl/sha1_sched.sv
hdl/sha1_round.sv
hdl/sha1_stream_hasher.sv
sim/tb_top.sv
